@@ rtl/core/mvf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the MessagePack value framer: shared widths, codes and the
// token that the front stage hands to the back stage. No dependencies.
package mvf_pkg;

    localparam int MAX_NESTING_DEF = 256;
    localparam int CNT_W           = 33;   // child / skip counts
    localparam int ACC_W           = 32;   // big-endian length header
    localparam int NEST_W          = 9;    // reported nesting level
    localparam int SMALL_W         = 5;    // counts carried in a marker
    localparam int HDR_W           = 3;    // header length in bytes
    localparam int Q_DEPTH         = 2;    // front-to-back queue

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNC      = 3'd1,
        ST_BAD_MARKER = 3'd2,
        ST_TOO_DEEP   = 3'd3,
        ST_DISCARD    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_MARKER = 2'd0,
        PH_HEADER = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        HK_PAYLOAD = 2'd0,
        HK_EXT     = 2'd1,
        HK_ARRAY   = 2'd2,
        HK_MAP     = 2'd3
    } t_hkind;

    // Class of a byte read as a marker.
    typedef enum logic [2:0] {
        MC_SCALAR = 3'd0,
        MC_SKIP   = 3'd1,
        MC_OPEN   = 3'd2,
        MC_HDR    = 3'd3,
        MC_BAD    = 3'd4
    } t_mclass;

    typedef enum logic {
        BK_RUN     = 1'b0,
        BK_CASCADE = 1'b1
    } t_bk_state;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               eod;
        t_mclass            mclass;
        logic [SMALL_W-1:0] cnt;
        logic [HDR_W-1:0]   hwidth;
        t_hkind             hkind;
        logic               strbin;
    } t_tok;

endpackage

@@ rtl/core/mvf_in_if.sv @@
`timescale 1ns / 1ps
// Byte input channel of the MessagePack value framer.
// Depends on nothing.
interface mvf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

@@ rtl/core/mvf_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the MessagePack value framer.
// Depends on mvf_pkg for the field widths.
interface mvf_out_if import mvf_pkg::*;;
    logic              valid;
    logic              ready;
    logic              value_done;
    logic [2:0]        status;
    logic [NEST_W-1:0] nesting_now;

    modport source (output valid, output value_done, output status, output nesting_now,
                    input ready);
    modport sink   (input valid, input value_done, input status, input nesting_now,
                    output ready);
endinterface

@@ rtl/core/mvf_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mvf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/core/mvf_front.sv @@
`timescale 1ns / 1ps
// Front stage: take each byte, classify it as a marker, register the token.
// Depends on mvf_pkg and mvf_in_if.
module mvf_front import mvf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mvf_in_if.sink i_in,
    output logic   o_tok_valid,
    input  logic   i_tok_ready,
    output t_tok   o_tok
);
    logic       r_tv;
    t_tok       r_tok;
    t_tok       dec;
    logic [7:0] m;
    logic       take;

    assign m        = i_in.data_byte;
    assign i_in.ready = !r_tv || i_tok_ready;
    assign take     = i_in.valid && i_in.ready;

    // Marker decode; the back stage only uses it when it expects a marker.
    always_comb begin
        dec           = '0;
        dec.data_byte = m;
        dec.eod       = i_in.end_of_data;
        dec.mclass    = MC_SCALAR;
        dec.hkind     = HK_PAYLOAD;
        dec.strbin    = (m >= 8'hc4 && m <= 8'hc6) || (m >= 8'hd9 && m <= 8'hdb);
        if (m <= 8'h7f || m >= 8'he0) begin
            dec.mclass = MC_SCALAR;
        end else if (m[7:5] == 3'b101) begin
            dec.mclass = MC_SKIP;
            dec.cnt    = m[4:0];
        end else if (m[7:4] == 4'h9) begin
            dec.mclass = MC_OPEN;
            dec.cnt    = {1'b0, m[3:0]};
        end else if (m[7:4] == 4'h8) begin
            dec.mclass = MC_OPEN;
            dec.cnt    = {m[3:0], 1'b0};
        end else begin
            case (m)
                8'hc0, 8'hc2, 8'hc3: begin
                    dec.mclass = MC_SCALAR;
                end
                8'hc4, 8'hd9: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd1;
                end
                8'hc5, 8'hda: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd2;
                end
                8'hc6, 8'hdb: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd4;
                end
                8'hc7: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd1;
                    dec.hkind  = HK_EXT;
                end
                8'hc8: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd2;
                    dec.hkind  = HK_EXT;
                end
                8'hc9: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd4;
                    dec.hkind  = HK_EXT;
                end
                8'hcc, 8'hd0: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd1;
                end
                8'hcd, 8'hd1, 8'hd4: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd2;
                end
                8'hd5: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd3;
                end
                8'hca, 8'hce, 8'hd2: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd4;
                end
                8'hd6: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd5;
                end
                8'hcb, 8'hcf, 8'hd3: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd8;
                end
                8'hd7: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd9;
                end
                8'hd8: begin
                    dec.mclass = MC_SKIP;
                    dec.cnt    = 5'd17;
                end
                8'hdc: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd2;
                    dec.hkind  = HK_ARRAY;
                end
                8'hdd: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd4;
                    dec.hkind  = HK_ARRAY;
                end
                8'hde: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd2;
                    dec.hkind  = HK_MAP;
                end
                8'hdf: begin
                    dec.mclass = MC_HDR;
                    dec.hwidth = 3'd4;
                    dec.hkind  = HK_MAP;
                end
                default: begin
                    dec.mclass = MC_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (take) begin
            r_tv <= 1'b1;
        end else if (i_tok_ready) begin
            r_tv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok <= dec;
        end
    end

    assign o_tok_valid = r_tv;
    assign o_tok       = r_tok;
endmodule

@@ rtl/core/mvf_queue.sv @@
`timescale 1ns / 1ps
// Short token queue between the front and back stages.
// Depends on mvf_pkg.
module mvf_queue import mvf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_tok i_push_tok,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_tok o_pop_tok
);
    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_tok              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_QW-1:0] r_cnt;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;
    logic [CNT_QW-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != CNT_QW'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_tok    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CNT_QW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_tok;
        end
    end
endmodule

@@ rtl/core/mvf_back.sv @@
`timescale 1ns / 1ps
// Back stage: parse phase, header and skip counters, container stack, result register.
// Depends on mvf_pkg, mvf_out_if and mvf_ram.
module mvf_back import mvf_pkg::*; #(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tok_valid,
    output logic      o_tok_ready,
    input  t_tok      i_tok,
    mvf_out_if.source o_out
);
    localparam int LVL_W = $clog2(MAX_NESTING + 2);
    localparam int AW    = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_CLOSE = 3'd1,
        ACT_PUSH  = 3'd2,
        ACT_SKIP  = 3'd3,
        ACT_HDR   = 3'd4
    } t_act;

    t_bk_state         r_bk_state, n_bk_state;
    logic [LVL_W-1:0]  r_level, n_level;
    logic [CNT_W-1:0]  r_top, n_top;
    t_phase            r_phase, n_phase;
    t_hkind            r_hkind, n_hkind;
    logic [HDR_W-1:0]  r_hleft, n_hleft;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_skip, n_skip;
    logic              r_err, n_err;
    logic              r_cas_eod, n_cas_eod;

    logic              r_ov;
    logic              r_done;
    t_status           r_status;
    logic [NEST_W-1:0] r_nest;

    t_act              act;
    logic [CNT_W-1:0]  cnt;
    t_status           st;
    t_status           em_status;
    logic [NEST_W-1:0] em_nest;
    logic              done_v;
    logic              emit;
    logic              go_cas;
    logic              eod_v;
    logic              deep;
    logic              slot_free;
    logic              take;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CNT_W-1:0]  rd_data;

    assign slot_free   = !r_ov || o_out.ready;
    assign o_tok_ready = (r_bk_state == BK_RUN) && slot_free;
    assign take        = i_tok_valid && o_tok_ready;
    assign deep        = (r_level > LVL_W'(MAX_NESTING));

    // Entries below the top of the stack; the top itself lives in r_top.
    mvf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_top),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_level   = r_level;
        n_top     = r_top;
        n_phase   = r_phase;
        n_hkind   = r_hkind;
        n_hleft   = r_hleft;
        n_acc     = r_acc;
        n_skip    = r_skip;
        n_err     = r_err;
        n_cas_eod = r_cas_eod;
        act       = ACT_NONE;
        cnt       = '0;
        st        = ST_OK;
        done_v    = 1'b0;
        emit      = 1'b0;
        go_cas    = 1'b0;
        eod_v     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        rd_en     = 1'b0;
        rd_addr   = '0;

        if (take) begin
            eod_v = i_tok.eod;
            if (r_err) begin
                st = ST_DISCARD;
            end else if (r_phase == PH_HEADER) begin
                n_acc   = {r_acc[ACC_W-9:0], i_tok.data_byte};
                n_hleft = r_hleft - HDR_W'(1);
                if (r_hleft == HDR_W'(1)) begin
                    n_phase = PH_MARKER;
                    case (r_hkind)
                        HK_PAYLOAD: begin
                            act = ACT_SKIP;
                            cnt = {1'b0, n_acc};
                        end
                        HK_EXT: begin
                            act = ACT_SKIP;
                            cnt = {1'b0, n_acc} + CNT_W'(1);
                        end
                        HK_ARRAY: begin
                            act = ACT_PUSH;
                            cnt = {1'b0, n_acc};
                        end
                        HK_MAP: begin
                            act = ACT_PUSH;
                            cnt = {n_acc, 1'b0};
                        end
                        default: begin
                            act = ACT_NONE;
                        end
                    endcase
                end
            end else if (r_phase == PH_SKIP) begin
                if (r_skip == CNT_W'(1)) begin
                    n_phase = PH_MARKER;
                    n_skip  = '0;
                    act     = ACT_CLOSE;
                end else begin
                    n_skip = r_skip - CNT_W'(1);
                end
            end else begin
                // Strings and binaries pass at any depth; the depth check wins
                // over the unsupported-marker check.
                if (!i_tok.strbin && deep) begin
                    st = ST_TOO_DEEP;
                end else begin
                    case (i_tok.mclass)
                        MC_SCALAR: begin
                            act = ACT_CLOSE;
                        end
                        MC_SKIP: begin
                            act = ACT_SKIP;
                            cnt = CNT_W'(i_tok.cnt);
                        end
                        MC_OPEN: begin
                            act = ACT_PUSH;
                            cnt = CNT_W'(i_tok.cnt);
                        end
                        MC_HDR: begin
                            act = ACT_HDR;
                        end
                        default: begin
                            st = ST_BAD_MARKER;
                        end
                    endcase
                end
            end

            // Empty payload or empty container completes at once.
            if ((act == ACT_SKIP || act == ACT_PUSH) && cnt == '0) begin
                act = ACT_CLOSE;
            end

            case (act)
                ACT_CLOSE: begin
                    if (r_level == '0) begin
                        done_v = 1'b1;
                    end else if (r_top > CNT_W'(1)) begin
                        n_top = r_top - CNT_W'(1);
                    end else begin
                        n_level = r_level - LVL_W'(1);
                        if (r_level == LVL_W'(1)) begin
                            done_v = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_level - LVL_W'(2));
                            go_cas  = 1'b1;
                        end
                    end
                end
                ACT_PUSH: begin
                    if (r_level != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_level - LVL_W'(1));
                    end
                    n_top   = cnt;
                    n_level = r_level + LVL_W'(1);
                end
                ACT_SKIP: begin
                    n_phase = PH_SKIP;
                    n_skip  = cnt;
                end
                ACT_HDR: begin
                    n_phase = PH_HEADER;
                    n_hleft = i_tok.hwidth;
                    n_acc   = '0;
                    n_hkind = i_tok.hkind;
                end
                default: begin
                    n_phase = n_phase;
                end
            endcase

            if (st == ST_TOO_DEEP || st == ST_BAD_MARKER) begin
                n_err = 1'b1;
            end

            if (go_cas) begin
                n_cas_eod = i_tok.eod;
            end else begin
                emit = 1'b1;
            end
        end else if (r_bk_state == BK_CASCADE && slot_free) begin
            // Parent count is back from the stack RAM: decrement or pop again.
            eod_v = r_cas_eod;
            if (rd_data > CNT_W'(1)) begin
                n_top = rd_data - CNT_W'(1);
                emit  = 1'b1;
            end else begin
                n_level = r_level - LVL_W'(1);
                if (r_level == LVL_W'(1)) begin
                    done_v = 1'b1;
                    emit   = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_level - LVL_W'(2));
                end
            end
        end

        em_status = st;
        if (emit && eod_v && st == ST_OK && (n_phase != PH_MARKER || n_level != '0)) begin
            em_status = ST_TRUNC;
        end
        em_nest = NEST_W'(n_level);

        // End of buffer: drop everything so the next byte opens a new buffer.
        if (emit && eod_v) begin
            n_level = '0;
            n_phase = PH_MARKER;
            n_hkind = HK_PAYLOAD;
            n_hleft = '0;
            n_acc   = '0;
            n_skip  = '0;
            n_err   = 1'b0;
        end
    end

    always_comb begin
        case (r_bk_state)
            BK_RUN: begin
                n_bk_state = go_cas ? BK_CASCADE : BK_RUN;
            end
            BK_CASCADE: begin
                n_bk_state = emit ? BK_RUN : BK_CASCADE;
            end
            default: begin
                n_bk_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk_state <= BK_RUN;
            r_level    <= '0;
            r_phase    <= PH_MARKER;
            r_hkind    <= HK_PAYLOAD;
            r_hleft    <= '0;
            r_err      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_bk_state <= n_bk_state;
            r_level    <= n_level;
            r_phase    <= n_phase;
            r_hkind    <= n_hkind;
            r_hleft    <= n_hleft;
            r_err      <= n_err;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_acc     <= n_acc;
        r_skip    <= n_skip;
        r_cas_eod <= n_cas_eod;
        if (emit) begin
            r_done   <= done_v;
            r_status <= em_status;
            r_nest   <= em_nest;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.value_done  = r_done;
    assign o_out.status      = r_status;
    assign o_out.nesting_now = r_nest;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_NESTING + 1))
        else $error("nesting level beyond stack capacity");

    a_cascade_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bk_state == BK_CASCADE |-> r_level != '0 && r_phase == PH_MARKER)
        else $error("close cascade without an open container");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_hleft != '0 && r_hleft <= HDR_W'(4))
        else $error("header byte count out of range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !go_cas) |=> r_ov)
        else $error("accepted token gave no result");
endmodule

@@ rtl/core/msgpack_value_framer.sv @@
`timescale 1ns / 1ps
// Top level of the MessagePack value framer.
// Depends on mvf_pkg, mvf_in_if, mvf_out_if, mvf_front, mvf_queue, mvf_back.
//
// Feed a MessagePack buffer one byte per transfer on i_in, with end_of_data
// set on its last byte; every input transfer yields exactly one output
// transfer on o_out, in order. value_done marks the byte that completes a
// top-level value, nesting_now gives the open-container count after the byte
// (before the end-of-buffer clear), and status reports truncation at the end
// byte, the unsupported marker 0xc1 and nesting beyond MAX_NESTING; after an
// error every byte up to and including the end byte comes back as discarded.
// Throughput is one byte per cycle while results are taken and no close
// cascade runs. The count of the innermost open container stays in a register;
// the counts around it sit in the stack RAM (a MAX_NESTING-deep RAM with one
// write and one registered read port), and every entry read back holds the
// back stage: a byte that closes containers holds it unless it closes only a
// top-level one. A result passes the front register, the queue and the result
// register before it is offered.
// The stack RAM needs no clearing pass: entries are written before being read.
module msgpack_value_framer import mvf_pkg::*; #(
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvf_in_if.sink    i_in,
    mvf_out_if.source o_out
);
    logic f_valid;
    logic f_ready;
    t_tok f_tok;
    logic q_valid;
    logic q_ready;
    t_tok q_tok;

    // Classify each byte as a marker and register it.
    mvf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok_valid (f_valid),
        .i_tok_ready (f_ready),
        .o_tok       (f_tok)
    );

    // Absorb back-stage stalls during close cascades.
    mvf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_tok   (f_tok),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_tok    (q_tok)
    );

    // Track phase, counters and the container stack; drive the result.
    mvf_back #(
        .MAX_NESTING (MAX_NESTING)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .o_tok_ready (q_ready),
        .i_tok       (q_tok),
        .o_out       (o_out)
    );
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for msgpack_value_framer: feeds MessagePack buffers byte by byte
// and checks every result against a byte-level framing predictor kept in this file.
// Depends on mvf_pkg, mvf_in_if, mvf_out_if and the framer RTL.
module testbench;
    import mvf_pkg::*;

    // Bench knobs
    localparam int          DEPTH_LIMIT    = MAX_NESTING_DEF;
    localparam int          IDLE_PCT       = 34;    // share of idle cycles on either side
    localparam int          RANDOM_ITEMS   = 300;   // random bytes to send
    localparam int          NEST_CAP       = 5;     // container depth of random values
    localparam int          RX_HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int          STALL_LIMIT    = 5000;  // cycles with no transfer at all
    localparam int          SETTLE_CYCLES  = 16;    // quiet time after the last result
    localparam int          MAX_REPORTS    = 10;

    // MessagePack marker bytes
    localparam logic [7:0] MK_POSFIX_MAX = 8'h7f;
    localparam logic [7:0] MK_FIXMAP     = 8'h80;
    localparam logic [7:0] MK_FIXARRAY   = 8'h90;
    localparam logic [7:0] MK_FIXSTR     = 8'ha0;
    localparam logic [7:0] MK_NIL        = 8'hc0;
    localparam logic [7:0] MK_NEVER_USED = 8'hc1;
    localparam logic [7:0] MK_FALSE      = 8'hc2;
    localparam logic [7:0] MK_TRUE       = 8'hc3;
    localparam logic [7:0] MK_BIN8       = 8'hc4;
    localparam logic [7:0] MK_BIN16      = 8'hc5;
    localparam logic [7:0] MK_BIN32      = 8'hc6;
    localparam logic [7:0] MK_EXT8       = 8'hc7;
    localparam logic [7:0] MK_EXT16      = 8'hc8;
    localparam logic [7:0] MK_EXT32      = 8'hc9;
    localparam logic [7:0] MK_FLOAT32    = 8'hca;
    localparam logic [7:0] MK_FLOAT64    = 8'hcb;
    localparam logic [7:0] MK_UINT8      = 8'hcc;
    localparam logic [7:0] MK_UINT16     = 8'hcd;
    localparam logic [7:0] MK_UINT32     = 8'hce;
    localparam logic [7:0] MK_UINT64     = 8'hcf;
    localparam logic [7:0] MK_INT8       = 8'hd0;
    localparam logic [7:0] MK_INT16      = 8'hd1;
    localparam logic [7:0] MK_INT32      = 8'hd2;
    localparam logic [7:0] MK_INT64      = 8'hd3;
    localparam logic [7:0] MK_FIXEXT1    = 8'hd4;
    localparam logic [7:0] MK_FIXEXT2    = 8'hd5;
    localparam logic [7:0] MK_FIXEXT4    = 8'hd6;
    localparam logic [7:0] MK_FIXEXT8    = 8'hd7;
    localparam logic [7:0] MK_FIXEXT16   = 8'hd8;
    localparam logic [7:0] MK_STR8       = 8'hd9;
    localparam logic [7:0] MK_STR16      = 8'hda;
    localparam logic [7:0] MK_STR32      = 8'hdb;
    localparam logic [7:0] MK_ARRAY16    = 8'hdc;
    localparam logic [7:0] MK_ARRAY32    = 8'hdd;
    localparam logic [7:0] MK_MAP16      = 8'hde;
    localparam logic [7:0] MK_MAP32      = 8'hdf;
    localparam logic [7:0] MK_NEGFIX     = 8'he0;

    // One expected result per byte
    typedef struct packed {
        logic              done;
        t_status           status;
        logic [NEST_W-1:0] level;
    } t_byte_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mvf_in_if  in_bus ();
    mvf_out_if out_bus ();

    msgpack_value_framer #(
        .MAX_NESTING (DEPTH_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framing predictor: its own copy of the scan state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] child_left [0:DEPTH_LIMIT];  // children still due per open container
    int unsigned      open_depth;
    t_phase           scan_phase;
    t_hkind           hdr_kind;
    int unsigned      hdr_left;
    logic [ACC_W-1:0] hdr_len;
    logic [CNT_W-1:0] payload_left;
    bit               err_latched;

    t_byte_verdict    verdicts_due [$];   // results still to arrive, oldest first
    logic [7:0]       frame_bytes [$];   // buffer under construction

    // Run statistics
    int unsigned bytes_sent, buffers_sent, values_framed, results_seen, deepest;
    int unsigned status_seen [0:4];
    int unsigned mismatch_count;

    // Side controls
    bit          tx_steady, rx_steady;   // suppress random idling
    int unsigned rx_hold_left = 0;       // loaded by a test, counted down below

    function automatic void clear_scan_state();
        open_depth   = 0;
        scan_phase   = PH_MARKER;
        hdr_kind     = HK_PAYLOAD;
        hdr_left     = 0;
        hdr_len      = '0;
        payload_left = '0;
        err_latched  = 1'b0;
    endfunction

    // Count one finished element against its container; close as many levels as run out.
    function automatic bit finish_element();
        while (open_depth > 0) begin
            if (child_left[open_depth - 1] > 1) begin
                child_left[open_depth - 1] = child_left[open_depth - 1] - 1'b1;
                return 1'b0;
            end
            open_depth = open_depth - 1;
        end
        return 1'b1;
    endfunction

    function automatic bit open_group(logic [CNT_W-1:0] n);
        if (n == 0) return finish_element();
        if (open_depth <= DEPTH_LIMIT) begin
            child_left[open_depth] = n;
            open_depth = open_depth + 1;
        end
        return 1'b0;
    endfunction

    function automatic bit begin_payload(logic [CNT_W-1:0] n);
        if (n == 0) return finish_element();
        payload_left = n;
        scan_phase   = PH_SKIP;
        return 1'b0;
    endfunction

    function automatic void begin_header(int unsigned nbytes, t_hkind kind);
        scan_phase = PH_HEADER;
        hdr_left   = nbytes;
        hdr_len    = '0;
        hdr_kind   = kind;
    endfunction

    function automatic bit take_marker(logic [7:0] m, output t_status st);
        bit strbin;
        st = ST_OK;
        strbin = (m >= MK_BIN8 && m <= MK_BIN32) || (m >= MK_STR8 && m <= MK_STR32);
        // depth check wins over the unsupported marker; strings and binaries pass any depth
        if (!strbin && open_depth > DEPTH_LIMIT) begin
            st = ST_TOO_DEEP;
            return 1'b0;
        end
        if (m <= MK_POSFIX_MAX || m >= MK_NEGFIX || m == MK_NIL || m == MK_FALSE || m == MK_TRUE)
            return finish_element();
        if ((m & 8'he0) == MK_FIXSTR)  return begin_payload(CNT_W'(m[4:0]));
        if ((m & 8'hf0) == MK_FIXARRAY) return open_group(CNT_W'(m[3:0]));
        if ((m & 8'hf0) == MK_FIXMAP)   return open_group(CNT_W'({m[3:0], 1'b0}));
        case (m)
            MK_BIN8,  MK_STR8:  begin_header(1, HK_PAYLOAD);
            MK_BIN16, MK_STR16: begin_header(2, HK_PAYLOAD);
            MK_BIN32, MK_STR32: begin_header(4, HK_PAYLOAD);
            MK_EXT8:            begin_header(1, HK_EXT);
            MK_EXT16:           begin_header(2, HK_EXT);
            MK_EXT32:           begin_header(4, HK_EXT);
            MK_UINT8,  MK_INT8:             return begin_payload(1);
            MK_UINT16, MK_INT16:            return begin_payload(2);
            MK_FLOAT32, MK_UINT32, MK_INT32: return begin_payload(4);
            MK_FLOAT64, MK_UINT64, MK_INT64: return begin_payload(8);
            MK_FIXEXT1:         return begin_payload(2);
            MK_FIXEXT2:         return begin_payload(3);
            MK_FIXEXT4:         return begin_payload(5);
            MK_FIXEXT8:         return begin_payload(9);
            MK_FIXEXT16:        return begin_payload(17);
            MK_ARRAY16:         begin_header(2, HK_ARRAY);
            MK_ARRAY32:         begin_header(4, HK_ARRAY);
            MK_MAP16:           begin_header(2, HK_MAP);
            MK_MAP32:           begin_header(4, HK_MAP);
            default:            st = ST_BAD_MARKER;
        endcase
        return 1'b0;
    endfunction

    // Advance the scan state by one byte and give the result it must produce.
    function automatic t_byte_verdict frame_byte(logic [7:0] b, logic eod);
        t_byte_verdict v;
        t_status       st;
        bit            done;
        st   = ST_OK;
        done = 1'b0;
        if (err_latched) begin
            st = ST_DISCARD;
        end else if (scan_phase == PH_HEADER) begin
            hdr_len = {hdr_len[ACC_W-9:0], b};
            if (hdr_left > 0) hdr_left = hdr_left - 1;
            if (hdr_left == 0) begin
                scan_phase = PH_MARKER;
                case (hdr_kind)
                    HK_PAYLOAD: done = begin_payload({1'b0, hdr_len});
                    HK_EXT:     done = begin_payload({1'b0, hdr_len} + 1'b1);
                    HK_ARRAY:   done = open_group({1'b0, hdr_len});
                    default:    done = open_group({hdr_len, 1'b0});
                endcase
            end
        end else if (scan_phase == PH_SKIP) begin
            if (payload_left > 0) payload_left = payload_left - 1'b1;
            if (payload_left == 0) begin
                scan_phase = PH_MARKER;
                done       = finish_element();
            end
        end else begin
            done = take_marker(b, st);
        end
        if (st == ST_BAD_MARKER || st == ST_TOO_DEEP) begin
            err_latched = 1'b1;
            done        = 1'b0;
        end
        v.done  = done;
        v.level = NEST_W'(open_depth);
        if (eod) begin
            if (st == ST_OK && (scan_phase != PH_MARKER || open_depth != 0)) st = ST_TRUNC;
            clear_scan_state();
        end
        v.status = st;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Buffer construction
    // ------------------------------------------------------------------
    function automatic void push_be(logic [31:0] v, int unsigned nbytes);
        for (int k = int'(nbytes) - 1; k >= 0; k--) frame_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic void push_noise(int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    // Open a chain of containers that each still wait for one element, one level each.
    function automatic void push_opens(int unsigned levels);
        repeat (levels) begin
            case ($urandom_range(0, 2))
                0: frame_bytes.push_back(MK_FIXARRAY | 8'h01);
                1: begin
                    frame_bytes.push_back(MK_FIXMAP | 8'h01);
                    frame_bytes.push_back(8'($urandom_range(0, MK_POSFIX_MAX)));
                end
                default: begin
                    frame_bytes.push_back(MK_ARRAY16);
                    push_be(1, 2);
                end
            endcase
        end
    endfunction

    // Open a chain of one-element fixarrays, one byte per level.
    function automatic void push_plain_opens(int unsigned levels);
        repeat (levels) frame_bytes.push_back(MK_FIXARRAY | 8'h01);
    endfunction

    // Append one well-formed value with random content.
    function automatic void emit_value(int unsigned lvl);
        int unsigned pick, k, n;
        pick = $urandom_range(0, (lvl < NEST_CAP) ? 11 : 7);
        k    = $urandom_range(0, 2);
        n    = $urandom_range(0, 3);
        // now and then a wide container at the top
        if (lvl == 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, 15);
        case (pick)
            0: frame_bytes.push_back(8'($urandom_range(0, MK_POSFIX_MAX)));
            1: frame_bytes.push_back(8'($urandom_range(MK_NEGFIX, 8'hff)));
            2: frame_bytes.push_back(k == 0 ? MK_NIL : (k == 1 ? MK_FALSE : MK_TRUE));
            3: begin
                k = $urandom_range(0, 9);
                if (k < 8) begin
                    frame_bytes.push_back(MK_UINT8 + 8'(k));
                    push_noise(1 << (k % 4));
                end else begin
                    frame_bytes.push_back(k == 8 ? MK_FLOAT32 : MK_FLOAT64);
                    push_noise(k == 8 ? 4 : 8);
                end
            end
            4: begin
                k = $urandom_range(0, 4);
                frame_bytes.push_back(MK_FIXEXT1 + 8'(k));
                push_noise((1 << k) + 1);
            end
            5: begin
                n = $urandom_range(0, 31);
                frame_bytes.push_back(MK_FIXSTR | 8'(n));
                push_noise(n);
            end
            6: begin
                n = $urandom_range(0, 24);
                frame_bytes.push_back(($urandom_range(0, 1) ? MK_STR8 : MK_BIN8) + 8'(k));
                push_be(n, 1 << k);
                push_noise(n);
            end
            7: begin
                n = $urandom_range(0, 16);
                frame_bytes.push_back(MK_EXT8 + 8'(k));
                push_be(n, 1 << k);
                push_noise(n + 1);   // type byte, then payload
            end
            8: begin
                frame_bytes.push_back(MK_FIXARRAY | 8'(n));
                repeat (n) emit_value(lvl + 1);
            end
            9: begin
                frame_bytes.push_back(MK_FIXMAP | 8'(n));
                repeat (2 * n) emit_value(lvl + 1);
            end
            10: begin
                k = $urandom_range(0, 1);
                frame_bytes.push_back(MK_ARRAY16 + 8'(k));
                push_be(n, 2 << k);
                repeat (n) emit_value(lvl + 1);
            end
            default: begin
                k = $urandom_range(0, 1);
                frame_bytes.push_back(MK_MAP16 + 8'(k));
                push_be(n, 2 << k);
                repeat (2 * n) emit_value(lvl + 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one byte, hold it until the transfer, then record what must come back.
    task automatic send_byte(logic [7:0] b, logic eod);
        t_byte_verdict v;
        while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= b;
        in_bus.end_of_data <= eod;
        do @(posedge i_clk); while (!in_bus.ready);
        v = frame_byte(b, eod);
        verdicts_due.push_back(v);
        bytes_sent++;
        status_seen[int'(v.status)]++;
        if (v.done) values_framed++;
        if (v.level > deepest) deepest = v.level;
    endtask

    // Send the buffer under construction, end-of-data on its last byte.
    task automatic send_buffer();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        frame_bytes.delete();
        buffers_sent++;
    endtask

    // Drop valid and hold the sender until every result has come back.
    task automatic wait_for_drain();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (verdicts_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_scalar_extremes();
        frame_bytes = '{8'h00, MK_POSFIX_MAX, MK_NEGFIX, 8'hff, MK_NIL, MK_FALSE, MK_TRUE};
        send_buffer();
    endtask

    // Array of a short string and an empty map: the last byte completes the map and closes the array.
    task automatic test_small_containers();
        frame_bytes = '{MK_FIXARRAY | 8'h02, MK_FIXSTR | 8'h01, 8'h41, MK_FIXMAP};
        send_buffer();
    endtask

    // Unsupported marker, then a discarded end byte; then the error on the end byte itself.
    task automatic test_bad_marker();
        frame_bytes = '{MK_NEVER_USED, 8'h00};
        send_buffer();
        frame_bytes = '{MK_NEVER_USED};
        send_buffer();
    endtask

    // End of data inside a length header, and inside a huge map.
    task automatic test_truncation();
        frame_bytes = '{MK_STR32, 8'hff};
        send_buffer();
        frame_bytes = '{MK_MAP32, 8'hff, 8'hff, 8'hff, 8'hff};
        send_buffer();
    endtask

    task automatic test_nesting_limit();
        // full depth, then a binary that is still allowed: one byte closes every level
        push_plain_opens(DEPTH_LIMIT + 1);
        frame_bytes.push_back(MK_BIN8);
        frame_bytes.push_back(8'h00);
        send_buffer();
        // too deep beats the unsupported marker; the rest is discarded
        push_plain_opens(DEPTH_LIMIT + 1);
        frame_bytes.push_back(MK_NEVER_USED);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(MK_FIXARRAY);
        send_buffer();
        // a scalar exactly at the limit is fine
        push_plain_opens(DEPTH_LIMIT);
        frame_bytes.push_back(MK_NIL);
        send_buffer();
        // end of data with every level open
        push_plain_opens(DEPTH_LIMIT + 1);
        send_buffer();
    endtask

    // Hold the receiver off while the sender streams without gaps.
    task automatic test_backpressure();
        tx_steady = 1'b1;
        rx_hold_left <= RX_HOLD_CYCLES;
        while (frame_bytes.size() < 40) emit_value(0);
        send_buffer();
        tx_steady = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_random_buffers();
        int unsigned first, mode, cut, pos;
        first = bytes_sent;
        while (bytes_sent < first + RANDOM_ITEMS) begin
            // one long stretch where neither side idles
            tx_steady = (bytes_sent - first >= 60) && (bytes_sent - first < 210);
            rx_steady = tx_steady;
            mode = $urandom_range(0, 99);
            if (mode < 86) begin
                if (mode >= 55 && mode < 65) push_opens($urandom_range(1, 40));
                repeat ($urandom_range(1, 3)) emit_value(0);
                if (mode >= 65 && mode < 76) begin
                    cut = $urandom_range(1, frame_bytes.size());
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end else if (mode >= 76) begin
                    pos = $urandom_range(0, frame_bytes.size() - 1);
                    frame_bytes[pos] = (mode < 81) ? MK_NEVER_USED : 8'($urandom);
                end
            end else begin
                push_noise($urandom_range(1, 16));
            end
            send_buffer();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    function automatic void log_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
    end

    initial begin : result_checker
        t_byte_verdict want;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid && out_bus.ready) begin
                if (verdicts_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result done=%0b status=%0d nesting=%0d",
                        out_bus.value_done, out_bus.status, out_bus.nesting_now));
                end else begin
                    want = verdicts_due.pop_front();
                    results_seen++;
                    if (out_bus.value_done !== want.done || out_bus.status !== want.status ||
                        out_bus.nesting_now !== want.level)
                        log_mismatch($sformatf({"result %0d: expected done=%0b status=%0d ",
                            "nesting=%0d, got done=%0b status=%0d nesting=%0d"},
                            results_seen, want.done, want.status, want.level,
                            out_bus.value_done, out_bus.status, out_bus.nesting_now));
                end
            end
            out_bus.ready <= (rx_hold_left == 0) &&
                             (rx_steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // End the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
            STALL_LIMIT, verdicts_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        in_bus.valid       <= 1'b0;
        in_bus.data_byte   <= 8'h00;
        in_bus.end_of_data <= 1'b0;
        i_rst_n            <= 1'b0;
        clear_scan_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_scalar_extremes();
        test_small_containers();
        test_bad_marker();
        test_truncation();
        wait_for_drain();
        test_nesting_limit();
        wait_for_drain();
        test_backpressure();
        test_random_buffers();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d bytes in %0d buffers, %0d results checked, %0d values closed,",
            bytes_sent, buffers_sent, results_seen, values_framed);
        $display("     deepest level %0d; status mix: ok %0d, truncated %0d, bad marker %0d,",
            deepest, status_seen[0], status_seen[1], status_seen[2]);
        $display("     too deep %0d, discarded %0d", status_seen[3], status_seen[4]);
        if (mismatch_count == 0 && verdicts_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
